[sv/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Operation codes, status codes, slot and result layouts.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned AGE_W        = 8;
  localparam int unsigned PRI_W        = 8;
  localparam int unsigned OCC_W        = 4;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic [PRI_W-1:0] pri;
  } slot_t;

  typedef struct packed {
    status_e          status;
    logic             hit;
    slot_t            slot;
    logic [OCC_W-1:0] occupancy;
  } res_t;

endpackage

[sv/spq_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_store: sorted slot array with fill count
// Every slot compares against the new priority in parallel; one insert or
// head removal completes per cycle while op_en_i is high.
// ----------------------------------------------------------------------------
module spq_store #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_en_i,
  input  spq_pkg::cmd_e       cmd_i,
  input  spq_pkg::slot_t      slot_i,
  output spq_pkg::res_t       res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  spq_pkg::slot_t slots_q [CAPACITY];
  spq_pkg::slot_t enq_d   [CAPACITY];
  spq_pkg::slot_t deq_d   [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CntW-1:0] count_q, count_d;
  logic full, empty, enq_ok, deq_ok;

  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign enq_ok = (cmd_i == spq_pkg::CMD_ENQ) && !full;
  assign deq_ok = (cmd_i == spq_pkg::CMD_DEQ) && !empty;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    assign ge[k] = (count_q > CntW'(k)) && (slots_q[k].pri >= slot_i.pri);
    if (k == 0) begin : g_head
      assign enq_d[k] = ge[k] ? slots_q[k] : slot_i;
    end else begin : g_body
      assign enq_d[k] = ge[k] ? slots_q[k] : (ge[k-1] ? slot_i : slots_q[k-1]);
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign deq_d[k] = slots_q[k];
    end else begin : g_shift
      assign deq_d[k] = slots_q[k+1];
    end

    always_ff @(posedge clk_i) begin
      if (op_en_i && enq_ok) begin
        slots_q[k] <= enq_d[k];
      end else if (op_en_i && deq_ok) begin
        slots_q[k] <= deq_d[k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (op_en_i) begin
      count_q <= count_d;
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.status    = spq_pkg::ST_DONE;
    res_o.occupancy = spq_pkg::OCC_W'(count_d);
    if (cmd_i == spq_pkg::CMD_ENQ && full) begin
      res_o.status = spq_pkg::ST_FULL;
    end else if (cmd_i == spq_pkg::CMD_DEQ && empty) begin
      res_o.status = spq_pkg::ST_EMPTY;
    end else if (deq_ok) begin
      res_o.hit  = 1'b1;
      res_o.slot = slots_q[0];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_enq_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_en_i && enq_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("enqueue did not grow fill count");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> slots_q[0].pri >= slots_q[1].pri)
    else $error("head slots out of order");

  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_en_i && full && cmd_i == spq_pkg::CMD_ENQ |=> $stable(count_q))
    else $error("enqueue on full store changed fill count");

endmodule

[sv/sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: fixed-capacity sorted priority queue
// Enqueue inserts by priority (ties in arrival order); dequeue pops the head.
// ----------------------------------------------------------------------------
// One operation is accepted every cycle unless the input stalls, and its
// result beat appears in the output register in the next cycle. This rate
// comes from the parallel priority compare across all CAPACITY slots, which
// places or shifts every slot in the same clock. Input stalls only while a
// result beat waits in the output register and the downstream side stalls it.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [spq_pkg::ID_W-1:0]   item_id_i,
  input  logic [spq_pkg::AGE_W-1:0]  item_age_i,
  input  logic [spq_pkg::PRI_W-1:0]  item_priority_i,
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output logic [1:0]                 status_o,
  output logic                       out_valid_o,
  output logic [spq_pkg::ID_W-1:0]   out_id_o,
  output logic [spq_pkg::AGE_W-1:0]  out_age_o,
  output logic [spq_pkg::PRI_W-1:0]  out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]  occupancy_o
);

  logic           accept;
  logic           res_valid_q, res_valid_d;
  spq_pkg::slot_t slot_in;
  spq_pkg::res_t  res_d, res_q;

  assign in_stall_o = res_valid_q && res_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign slot_in.id  = item_id_i;
  assign slot_in.age = item_age_i;
  assign slot_in.pri = item_priority_i;

  spq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_en_i (accept),
    .cmd_i   (spq_pkg::cmd_e'(cmd_i)),
    .slot_i  (slot_in),
    .res_o   (res_d)
  );

  always_comb begin
    res_valid_d = res_valid_q && res_stall_i;
    if (accept) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign status_o       = res_q.status;
  assign out_valid_o    = res_q.hit;
  assign out_id_o       = res_q.slot.id;
  assign out_age_o      = res_q.slot.age;
  assign out_priority_o = res_q.slot.pri;
  assign occupancy_o    = res_q.occupancy;

endmodule
